// ----- src/ldr_pkg.sv -----
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared constants, register codes and a helper function for the distance restraint.
// ----------------------------------------------------------------------------
`default_nettype none

package ldr_pkg;

  localparam int ALPHA_W        = 32;
  localparam int TARGET_W       = 31;
  localparam int CFG_W          = 32;
  localparam int DEF_COORD_W    = 32;
  localparam int DEF_FRAC_BITS  = 20;
  localparam int DEF_RESULT_W   = 48;
  localparam int ALPHA_SHIFT    = 16;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 32'd65536;
  localparam logic [TARGET_W-1:0] TARGET_RST = 31'd1048576;

  typedef enum logic [0:0] {
    REG_ALPHA  = 1'b0,
    REG_TARGET = 1'b1
  } cfg_reg_e;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- src/linear_distance_restraint_force.sv -----
// ----------------------------------------------------------------------------
// linear_distance_restraint_force
// Energy and force of a linear distance restraint for one pair of sites.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o | pos_x/y/z_i, ref_x/y/z_i
//  out      | out_valid_o/out_stall_i | energy_o, force_x/y/z_o, flags
//  cfg      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  One request per cycle while in_stall_o is low. The pipe holds the square
//  root pipeline (one root bit per stage) and the lane dividers (one quotient
//  bit per stage). Reset clears the valid pipe, the output
//  buffer and the registers to alpha 1.0, target 1.0. A stalled output fills
//  a two-entry buffer; the pipe freezes only while both entries are held.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_distance_restraint_force import ldr_pkg::*; #(
  parameter int COORD_WIDTH  = DEF_COORD_W,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int RESULT_WIDTH = DEF_RESULT_W
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [0:0]                     cfg_idx_i,
  input  wire logic [CFG_W-1:0]               cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0]  pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  pos_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]  pos_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]  ref_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  ref_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]  ref_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [RESULT_WIDTH-1:0]             energy_o,
  output logic signed [RESULT_WIDTH-1:0]      force_x_o,
  output logic signed [RESULT_WIDTH-1:0]      force_y_o,
  output logic signed [RESULT_WIDTH-1:0]      force_z_o,
  output logic                                force_defined_o,
  output logic                                saturated_o
);

  localparam int MAG_W   = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int R_W     = MAG_W + 1;
  localparam int S_W     = 2 * R_W;
  localparam int PE_W    = ALPHA_W + R_W;
  localparam int EN_NAT  = PE_W + FRAC_BITS - ALPHA_SHIFT;
  localparam int NE_W    = maxi(EN_NAT, RESULT_WIDTH + 1);
  localparam int PF_W    = MAG_W + ALPHA_W;
  localparam int FN_NAT  = PF_W + 2 * FRAC_BITS - ALPHA_SHIFT;
  localparam int NF_W    = maxi(FN_NAT, RESULT_WIDTH + 1);
  localparam int DF_W    = TARGET_W + R_W;
  localparam int DIV_LAT = RESULT_WIDTH + 1;
  localparam int SIDE_W  = 3 * MAG_W + 5;
  localparam int LAT     = 3 + R_W + 1 + DIV_LAT;

  localparam logic [RESULT_WIDTH-1:0] HALF = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
  localparam logic [RESULT_WIDTH-1:0] SMAX = ~HALF;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] energy;
    logic [RESULT_WIDTH-1:0] fx;
    logic [RESULT_WIDTH-1:0] fy;
    logic [RESULT_WIDTH-1:0] fz;
    logic                    defined;
    logic                    sat;
  } res_t;

  // configuration
  logic [ALPHA_W-1:0]  alpha_q;
  logic [TARGET_W-1:0] target_q;
  logic [TARGET_W-1:0] t_eff;
  logic [2*TARGET_W-1:0] tsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RST;
      target_q <= TARGET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA:  alpha_q  <= cfg_wdata_i[ALPHA_W-1:0];
        REG_TARGET: target_q <= cfg_wdata_i[TARGET_W-1:0];
        default:    alpha_q  <= alpha_q;
      endcase
    end
  end

  assign t_eff = (target_q == '0) ? TARGET_W'(1) : target_q;

  always_ff @(posedge clk_i) begin
    tsq_q <= t_eff * t_eff;
  end

  // pipe control
  logic [1:0] cnt_q;
  logic       en;
  logic       vld_q [LAT];

  assign en         = ~cnt_q[1];
  assign in_stall_o = cnt_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // difference and magnitude
  logic [COORD_WIDTH-1:0] pos [3];
  logic [COORD_WIDTH-1:0] rf  [3];
  logic [MAG_W-1:0]       d   [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign rf[0]  = ref_x_i;
  assign rf[1]  = ref_y_i;
  assign rf[2]  = ref_z_i;

  logic [MAG_W-1:0] mag1_q [3];
  logic [MAG_W-1:0] mag2_q [3];
  logic [MAG_W-1:0] mag3_q [3];
  logic [2:0]       neg1_q, neg2_q, neg3_q;
  logic [SQ_W-1:0]  sq_q [3];
  logic [S_W-1:0]   s_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = {pos[i][COORD_WIDTH-1], pos[i]} - {rf[i][COORD_WIDTH-1], rf[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= d[i][MAG_W-1];
        mag1_q[i] <= d[i][MAG_W-1] ? (MAG_W'(0) - d[i]) : d[i];
        sq_q[i]   <= mag1_q[i] * mag1_q[i];
        mag2_q[i] <= mag1_q[i];
        mag3_q[i] <= mag2_q[i];
      end
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
      s_q    <= S_W'(sq_q[0]) + S_W'(sq_q[1]) + S_W'(sq_q[2]);
    end
  end

  // square root lane and sideband
  logic [S_W-1:0]    tsq_ext;
  logic              defined3, flip3;
  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_q [R_W];
  logic [R_W-1:0]    root;

  assign tsq_ext  = S_W'(tsq_q);
  assign defined3 = (s_q != '0) && (s_q != tsq_ext);
  assign flip3    = (s_q > tsq_ext);
  assign side_in  = {mag3_q[0], mag3_q[1], mag3_q[2], neg3_q, defined3, flip3};

  ldr_sqrt #(
    .ROOT_W (R_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < R_W; k++) side_q[k] <= side_q[k-1];
    end
  end

  // products
  logic [MAG_W-1:0] mag_r [3];
  logic [PE_W-1:0]  er_q;
  logic [DF_W-1:0]  tr_q;
  logic [PF_W-1:0]  fa_q [3];
  logic [4:0]       sm_q;

  assign mag_r[0] = side_q[R_W-1][SIDE_W-1 -: MAG_W];
  assign mag_r[1] = side_q[R_W-1][SIDE_W-1-MAG_W -: MAG_W];
  assign mag_r[2] = side_q[R_W-1][SIDE_W-1-2*MAG_W -: MAG_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      er_q <= alpha_q * root;
      tr_q <= t_eff * root;
      for (int i = 0; i < 3; i++) fa_q[i] <= mag_r[i] * alpha_q;
      sm_q <= side_q[R_W-1][4:0];
    end
  end

  // division lanes
  logic [PE_W+FRAC_BITS-1:0]   ewide;
  logic [PF_W+2*FRAC_BITS-1:0] fwide [3];
  logic [NE_W-1:0]             ne;
  logic [NF_W-1:0]             nf [3];
  logic [RESULT_WIDTH-1:0]     eq;
  logic                        ebig;
  logic [RESULT_WIDTH-1:0]     fq   [3];
  logic                        fbig [3];
  logic [4:0]                  sd_q [DIV_LAT];

  assign ewide = {er_q, {FRAC_BITS{1'b0}}};
  assign ne    = NE_W'(ewide[PE_W+FRAC_BITS-1:ALPHA_SHIFT]);

  ldr_div #(
    .NUM_W (NE_W),
    .DEN_W (TARGET_W),
    .QUO_W (RESULT_WIDTH)
  ) u_div_e (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ne),
    .den_i (t_eff),
    .quo_o (eq),
    .big_o (ebig)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign fwide[i] = {fa_q[i], {(2*FRAC_BITS){1'b0}}};
    assign nf[i]    = NF_W'(fwide[i][PF_W+2*FRAC_BITS-1:ALPHA_SHIFT]);

    ldr_div #(
      .NUM_W (NF_W),
      .DEN_W (DF_W),
      .QUO_W (RESULT_WIDTH)
    ) u_div_f (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nf[i]),
      .den_i (tr_q),
      .quo_o (fq[i]),
      .big_o (fbig[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sm_q;
      for (int k = 1; k < DIV_LAT; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // merge
  res_t                    res;
  logic [RESULT_WIDTH-1:0] fo   [3];
  logic                    fsat [3];
  logic [2:0]              negf;
  logic                    defd, flipd;

  assign negf  = sd_q[DIV_LAT-1][4:2];
  assign defd  = sd_q[DIV_LAT-1][1];
  assign flipd = sd_q[DIV_LAT-1][0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fo[i]   = '0;
      fsat[i] = 1'b0;
      if (defd) begin
        if (negf[i] ^ flipd) begin
          fsat[i] = fbig[i] || (fq[i] > HALF);
          fo[i]   = RESULT_WIDTH'(0) - (fsat[i] ? HALF : fq[i]);
        end else begin
          fsat[i] = fbig[i] || fq[i][RESULT_WIDTH-1];
          fo[i]   = fsat[i] ? SMAX : fq[i];
        end
      end
    end
    res.energy  = ebig ? '1 : eq;
    res.fx      = fo[0];
    res.fy      = fo[1];
    res.fz      = fo[2];
    res.defined = defd;
    res.sat     = ebig | fsat[0] | fsat[1] | fsat[2];
  end

  // output buffer
  res_t out_q, skid_q;
  logic push, pop;

  assign push = en & vld_q[LAT-1];
  assign pop  = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      priority case (1'b1)
        push && !pop: cnt_q <= cnt_q + 2'd1;
        pop && !push: cnt_q <= cnt_q - 2'd1;
        default:      cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (cnt_q == 2'd0 || pop) out_q  <= res;
      else                      skid_q <= res;
    end
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign energy_o        = out_q.energy;
  assign force_x_o       = out_q.fx;
  assign force_y_o       = out_q.fy;
  assign force_z_o       = out_q.fz;
  assign force_defined_o = out_q.defined;
  assign saturated_o     = out_q.sat;

endmodule

`default_nettype wire

// ----- src/ldr_sqrt.sv -----
// ----------------------------------------------------------------------------
// ldr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_sqrt import ldr_pkg::*; #(
  parameter int ROOT_W = 34
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [2*ROOT_W-1:0]   s_i,
  output logic      [ROOT_W-1:0]     root_o
);

  logic [ROOT_W+1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] sv_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] sv_in;
    logic [ROOT_W+1:0]   cur;
    logic [ROOT_W+1:0]   trial;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sv_in   = s_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sv_in   = sv_q[k-1];
    end

    assign cur   = {rem_in[ROOT_W-1:0], sv_in[2*ROOT_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (cur - trial) : cur;
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        sv_q[k]   <= sv_in << 2;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ----- src/ldr_div.sv -----
// ----------------------------------------------------------------------------
// ldr_div
// Pipelined restoring divider with overflow flag, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_div import ldr_pkg::*; #(
  parameter int NUM_W = 89,
  parameter int DEN_W = 65,
  parameter int QUO_W = 48
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic      [QUO_W-1:0]  quo_o,
  output logic                   big_o
);

  localparam int HI_W = NUM_W - QUO_W;
  localparam int CW   = maxi(HI_W, DEN_W);

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] low_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             big_q [QUO_W+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  assign hi_ext  = CW'(num_i[NUM_W-1:QUO_W]);
  assign den_ext = CW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_ext[DEN_W-1:0];
      low_q[0] <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      big_q[0] <= (hi_ext >= den_ext);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_q[k-1], low_q[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign take  = (trial >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], take};
        den_q[k] <= den_q[k-1];
        big_q[k] <= big_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign big_o = big_q[QUO_W];

endmodule

`default_nettype wire
